// ===== sv/gdfe_pkg.sv =====
// ----------------------------------------------------------------------------
// gdfe_pkg
// Shared types, codes and constants of the grid depth-first explorer.
// ----------------------------------------------------------------------------
package gdfe_pkg;

    // Default grid side; the top level parameter takes it
    localparam int GRID_SIDE_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0]  CFG_START_X   = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  CFG_START_Y   = 1'd1;
    localparam logic [CFG_DATA_W-1:0] START_POS_RST = 4'd8;

    // Stream widths
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;

    localparam int POS_W  = 4;   // result coordinate width
    localparam int HEAD_W = 2;
    localparam int IDX_W  = 10;  // move counter width

    // Depth of the request queue between front and engine
    localparam int Q_DEPTH = 2;

    typedef enum logic [0:0] {
        OP_START   = 1'b0,
        OP_OUTCOME = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CMD_FWD     = 2'd0,
        CMD_BACK    = 2'd1,
        CMD_DONE    = 2'd2,
        CMD_IGNORED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        HEAD_N = 2'd0,
        HEAD_W_ = 2'd1,
        HEAD_S = 2'd2,
        HEAD_E = 2'd3
    } t_head;

    // Request classes handed from front to engine
    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_ACCEPT = 2'd1,   // outcome, move went through
        REQ_RETRY  = 2'd2    // outcome, move was obstructed
    } t_req_kind;

    typedef struct packed {
        t_req_kind          kind;
        logic [HEAD_W-1:0]  heading;
        logic [POS_W-1:0]   start_x;   // already clamped to the grid
        logic [POS_W-1:0]   start_y;
    } t_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        t_cmd               cmd;
        logic [POS_W-1:0]   target_x;
        logic [POS_W-1:0]   target_y;
        logic [HEAD_W-1:0]  heading;
        logic [IDX_W-1:0]   move_index;
    } t_result;

    // Candidate order relative to the arrival heading: forward, left, right, back
    function automatic logic [HEAD_W-1:0] try_offset(input logic [2:0] idx);
        logic [HEAD_W-1:0] off;
        case (idx[1:0])
            2'd0:    off = 2'd0;
            2'd1:    off = 2'd1;
            2'd2:    off = 2'd3;
            default: off = 2'd2;
        endcase
        return off;
    endfunction

endpackage

// ===== sv/gdfe_front.sv =====
// ----------------------------------------------------------------------------
// gdfe_front
// Accepts input beats and configuration writes, classifies each beat into a
// request and pushes it into the request queue.
// ----------------------------------------------------------------------------
module gdfe_front import gdfe_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [1:0] start_heading, [2] obstructed
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,   // [0] operation
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_q_stat               i_q_stat,
    output logic                  o_push,
    output t_req                  o_req
);

    logic [POS_W-1:0] r_start_x;
    logic [POS_W-1:0] r_start_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= START_POS_RST;
            r_start_y <= START_POS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_START_X: r_start_x <= i_cfg_data;
                CFG_START_Y: r_start_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !i_q_stat.full;
    assign o_push          = i_s_axis_tvalid && !i_q_stat.full;

    always_comb begin
        // clamp a start cell beyond the grid to its last row or column
        o_req.start_x = (int'(r_start_x) > GRID_SIDE - 1) ? POS_W'(GRID_SIDE - 1) : r_start_x;
        o_req.start_y = (int'(r_start_y) > GRID_SIDE - 1) ? POS_W'(GRID_SIDE - 1) : r_start_y;
        o_req.heading = i_s_axis_tdata[1:0];
        if (t_op'(i_s_axis_tuser[0]) == OP_START) begin
            o_req.kind = REQ_START;
        end else if (i_s_axis_tdata[2]) begin
            o_req.kind = REQ_RETRY;
        end else begin
            o_req.kind = REQ_ACCEPT;
        end
    end

endmodule

// ===== sv/gdfe_queue.sv =====
// ----------------------------------------------------------------------------
// gdfe_queue
// Short FIFO of classified requests between the front and the engine.
// ----------------------------------------------------------------------------
module gdfe_queue import gdfe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_req    i_req,
    input  logic    i_pop,
    output t_req    o_req,
    output t_q_stat o_stat
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_req             r_ent [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_req        = r_ent[r_rd_ptr];
    assign o_stat.full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== sv/gdfe_engine.sv =====
// ----------------------------------------------------------------------------
// gdfe_engine
// Executes requests: visited map, frame stack, neighbor probing and the
// output register.
// ----------------------------------------------------------------------------
module gdfe_engine import gdfe_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_req    i_req,
    output logic    o_pop,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_result o_result
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int SPW   = AW + 1;
    localparam logic [CW-1:0] EDGE_HI   = CW'(GRID_SIDE - 1);
    localparam logic [2:0]    NEXT_DONE = 3'd4;

    typedef struct packed {
        logic [CW-1:0]     x;
        logic [CW-1:0]     y;
        logic [HEAD_W-1:0] dir;
        logic [2:0]        next;
    } t_frame;

    typedef enum logic [4:0] {
        S_WAIT  = 5'b00001,
        S_PROBE = 5'b00010,
        S_CHECK = 5'b00100,
        S_POP   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        PEND_IDLE = 2'd0,
        PEND_FWD  = 2'd1,
        PEND_BACK = 2'd2
    } t_pend;

    t_state             r_state, n_state;
    t_pend              r_pend, n_pend;
    logic [SPW-1:0]     r_sp, n_sp;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    t_frame             r_top, n_top;
    logic [CW-1:0]      r_cand_x, n_cand_x;
    logic [CW-1:0]      r_cand_y, n_cand_y;
    logic [HEAD_W-1:0]  r_cand_dir, n_cand_dir;
    t_result            r_res, n_res;
    t_result            r_out, n_out;
    logic               r_out_vld, n_out_vld;
    logic [GRID_SIDE-1:0] r_row_vld, n_row_vld;

    // visited map: one row per word, row valid bits stand in for clearing
    logic [GRID_SIDE-1:0] r_map [GRID_SIDE];
    logic [GRID_SIDE-1:0] r_row_q;
    logic                 map_we, map_re;
    logic [CW-1:0]        map_waddr, map_raddr;
    logic [GRID_SIDE-1:0] map_wdata;

    // frames below the top of stack
    t_frame               r_frames [CELLS];
    t_frame               r_frame_q;
    logic                 fr_we, fr_re;
    logic [AW-1:0]        fr_waddr, fr_raddr;

    logic [HEAD_W-1:0]    cand_dir;
    logic [CW-1:0]        cand_x, cand_y;
    logic                 off_grid;
    logic [GRID_SIDE-1:0] row_cur;

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            r_row_q <= r_map[map_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fr_we) begin
            r_frames[fr_waddr] <= r_top;
        end
        if (fr_re) begin
            r_frame_q <= r_frames[fr_raddr];
        end
    end

    // next candidate neighbor of the top frame
    always_comb begin
        cand_dir = r_top.dir + try_offset(r_top.next);
        cand_x   = r_top.x;
        cand_y   = r_top.y;
        off_grid = 1'b0;
        unique case (t_head'(cand_dir))
            HEAD_N: begin
                off_grid = (r_top.y == EDGE_HI);
                cand_y   = r_top.y + 1'b1;
            end
            HEAD_W_: begin
                off_grid = (r_top.x == '0);
                cand_x   = r_top.x - 1'b1;
            end
            HEAD_S: begin
                off_grid = (r_top.y == '0);
                cand_y   = r_top.y - 1'b1;
            end
            HEAD_E: begin
                off_grid = (r_top.x == EDGE_HI);
                cand_x   = r_top.x + 1'b1;
            end
            default: ;
        endcase
    end

    assign row_cur = r_row_vld[r_cand_y] ? r_row_q : '0;

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_sp       = r_sp;
        n_cnt      = r_cnt;
        n_top      = r_top;
        n_cand_x   = r_cand_x;
        n_cand_y   = r_cand_y;
        n_cand_dir = r_cand_dir;
        n_res      = r_res;
        n_row_vld  = r_row_vld;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_m_ready;
        o_pop      = 1'b0;
        map_we     = 1'b0;
        map_re     = 1'b0;
        map_waddr  = r_cand_y;
        map_raddr  = cand_y;
        map_wdata  = '0;
        fr_we      = 1'b0;
        fr_re      = 1'b0;
        fr_waddr   = AW'(r_sp - 1'b1);
        fr_raddr   = AW'(r_sp - 2'd2);

        unique case (r_state)
            S_WAIT: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_req.kind == REQ_START) begin
                        // drop all progress, mark and push the start cell
                        n_top.x    = CW'(i_req.start_x);
                        n_top.y    = CW'(i_req.start_y);
                        n_top.dir  = i_req.heading;
                        n_top.next = '0;
                        n_sp       = SPW'(1);
                        n_cnt      = IDX_W'(1);
                        n_row_vld  = '0;
                        n_row_vld[CW'(i_req.start_y)] = 1'b1;
                        map_we     = 1'b1;
                        map_waddr  = CW'(i_req.start_y);
                        map_wdata[CW'(i_req.start_x)] = 1'b1;
                        n_state    = S_PROBE;
                    end else if (r_pend == PEND_IDLE) begin
                        n_res   = '{cmd: CMD_IGNORED, target_x: '0, target_y: '0,
                                    heading: '0, move_index: '0};
                        n_state = S_EMIT;
                    end else begin
                        if (i_req.kind == REQ_ACCEPT && r_pend == PEND_FWD) begin
                            // push the entered cell
                            fr_we      = 1'b1;
                            n_top.x    = r_cand_x;
                            n_top.y    = r_cand_y;
                            n_top.dir  = r_cand_dir;
                            n_top.next = '0;
                            n_sp       = r_sp + 1'b1;
                            n_cnt      = r_cnt + 1'b1;
                        end
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_top.next == NEXT_DONE) begin
                    n_cand_dir = r_top.dir;
                    if (r_sp == SPW'(1)) begin
                        n_sp    = '0;
                        n_pend  = PEND_IDLE;
                        n_res   = '{cmd: CMD_DONE, target_x: '0, target_y: '0,
                                    heading: '0, move_index: r_cnt};
                        n_state = S_EMIT;
                    end else begin
                        n_sp    = r_sp - 1'b1;
                        fr_re   = 1'b1;
                        n_state = S_POP;
                    end
                end else begin
                    n_top.next = r_top.next + 1'b1;
                    if (!off_grid) begin
                        map_re     = 1'b1;
                        n_cand_x   = cand_x;
                        n_cand_y   = cand_y;
                        n_cand_dir = cand_dir;
                        n_state    = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (row_cur[r_cand_x]) begin
                    n_state = S_PROBE;
                end else begin
                    // mark the target now, even if the move is later obstructed
                    map_we    = 1'b1;
                    map_wdata = row_cur;
                    map_wdata[r_cand_x]  = 1'b1;
                    n_row_vld[r_cand_y]  = 1'b1;
                    n_pend    = PEND_FWD;
                    n_res     = '{cmd: CMD_FWD, target_x: POS_W'(r_cand_x),
                                  target_y: POS_W'(r_cand_y), heading: r_cand_dir,
                                  move_index: r_cnt};
                    n_state   = S_EMIT;
                end
            end
            S_POP: begin
                n_top   = r_frame_q;
                n_res   = '{cmd: CMD_BACK, target_x: POS_W'(r_frame_q.x),
                            target_y: POS_W'(r_frame_q.y), heading: r_cand_dir,
                            move_index: r_cnt};
                n_cnt   = r_cnt + 1'b1;
                n_pend  = PEND_BACK;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_vld || i_m_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_WAIT;
                end
            end
            default: n_state = S_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_WAIT;
            r_pend    <= PEND_IDLE;
            r_sp      <= '0;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_sp      <= n_sp;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            r_row_vld <= n_row_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top      <= n_top;
        r_cand_x   <= n_cand_x;
        r_cand_y   <= n_cand_y;
        r_cand_dir <= n_cand_dir;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_m_valid = r_out_vld;
    assign o_result  = r_out;

endmodule

// ===== sv/grid_depth_first_explorer_unit.sv =====
// ----------------------------------------------------------------------------
// grid_depth_first_explorer_unit
// Depth-first explorer of a square grid with a visited map and frame stack.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser[0] is the operation (start or outcome), tdata carries
//   start_heading and the obstructed flag. Every accepted beat yields exactly
//   one master beat: tuser is the command (forward, backward, done, ignored),
//   tdata carries target cell, heading and move index.
//   Configuration channel: index 0 writes start_x, index 1 writes start_y;
//   write only while no beat is in flight. Ready is always high.
//   Throughput: one beat at a time through the engine. With the engine idle,
//   a beat leaves the queue, then the engine makes up to four neighbor
//   probes (an in-grid probe reads the row, then checks and marks; an
//   off-grid probe only advances), finds the cell exhausted if all are spent,
//   reads the frame stack on a pop and loads the result register.
//   A two-entry queue decouples input acceptance from the engine, and a
//   result register lets the engine start the next beat while a result
//   waits. When the receiver stalls, the result holds and the queue fills,
//   then tready drops. Reset (synchronous, active low) clears the queue,
//   the stack pointer, the move counter and the visited map; start
//   registers return to cell (8, 8). No clearing pass is needed.
// ----------------------------------------------------------------------------
module grid_depth_first_explorer_unit import gdfe_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [1:0] start_heading, [2] obstructed
    input  logic [S_TUSER_W-1:0]  i_s_axis_tuser,   // [0] operation
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [3:0] target_x, [7:4] target_y,
                                                    // [9:8] heading, [19:10] move_index
    output logic [M_TUSER_W-1:0]  o_m_axis_tuser,   // [1:0] command
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_q_stat q_stat;
    t_req    front_req;
    t_req    head_req;
    logic    q_push;
    logic    q_pop;
    t_result result;

    gdfe_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_stat        (q_stat),
        .o_push          (q_push),
        .o_req           (front_req)
    );

    gdfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (front_req),
        .i_pop   (q_pop),
        .o_req   (head_req),
        .o_stat  (q_stat)
    );

    gdfe_engine #(
        .GRID_SIDE (GRID_SIDE)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_stat  (q_stat),
        .i_req     (head_req),
        .o_pop     (q_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_result  (result)
    );

    // pack result fields, lowest field first, zero-fill to whole bytes
    assign o_m_axis_tdata = {4'b0000, result.move_index, result.heading,
                             result.target_y, result.target_x};
    assign o_m_axis_tuser = result.cmd;

    // queue never overflows: the front pushes only with room
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("request queue overflow");

    // engine never takes a request from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_stat.empty)
        else $error("request queue underflow");

    // ignored beats carry all-zero fields
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == CMD_IGNORED) |-> (o_m_axis_tdata == '0))
        else $error("ignored result with nonzero fields");

    // done beats carry zero target and heading
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == CMD_DONE) |-> (o_m_axis_tdata[9:0] == '0))
        else $error("done result with nonzero target");

endmodule
